[rtl/mcd_pkg.sv]
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types, register codes and window helpers for the corner detector.
// ----------------------------------------------------------------------------
package mcd_pkg;

  localparam int KS  = 5;           // window edge
  localparam int RAD = KS / 2;      // window radius
  localparam int RW  = 14;          // signed row width, covers lead-in rows
  localparam int HW  = 13;          // frame height register width
  localparam int MAX_HEIGHT = 4096;

  typedef logic [7:0] pix_t;
  typedef pix_t [KS-1:0] col_t;     // one window column, index is line delay
  typedef col_t [KS-1:0] win_t;     // [column][line]

  typedef enum logic [1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SHAPE_CROSS,
    SHAPE_X,
    SHAPE_DIAMOND,
    SHAPE_SQUARE
  } shape_t;

  typedef struct packed {
    logic       corner;
    pix_t       diff;
    logic [10:0] column;
    logic [11:0] row;
    logic       frame_end;
  } res_t;

  function automatic logic in_shape(shape_t s, int k, int j);
    int ay;
    int ax;
    ay = (k > RAD) ? k - RAD : RAD - k;
    ax = (j > RAD) ? j - RAD : RAD - j;
    case (s)
      SHAPE_CROSS:   return (ay == 0) || (ax == 0);
      SHAPE_X:       return ay == ax;
      SHAPE_DIAMOND: return (ay + ax) <= RAD;
      default:       return 1'b1;
    endcase
  endfunction

  // Max or min over the kept entries; an empty set gives the identity.
  function automatic pix_t reduce5(pix_t [KS-1:0] vals, logic [KS-1:0] keep,
                                   logic take_max);
    pix_t acc;
    acc = take_max ? 8'd0 : 8'd255;
    for (int j = 0; j < KS; j++) begin
      if (keep[j] && (take_max ? (vals[j] > acc) : (vals[j] < acc))) begin
        acc = vals[j];
      end
    end
    return acc;
  endfunction

endpackage

[rtl/morphological_corner_detector.sv]
// ----------------------------------------------------------------------------
// morphological_corner_detector
// 5x5 morphological corner detector over a raster stream of gray pixels.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | tdata pixel, tuser frame_start/filler
//  m_      | out | m_tvalid/m_tready | tdata diff/column/row, tuser corner,
//          |     |                   | tlast frame_end
//  cfg_    | in  | cfg_valid/ready   | cfg_index, cfg_data
//
//  One item per clock while the skid is not full and no config write settles;
//  an item passes the two window chains and their reduction stages on its way
//  to the output register. s_tready drops in the cycle after each config write
//  (and after reset) while the lead-in positions are recomputed for the new line width.
//  A two-entry output (register plus skid) lets one more item in while a
//  result waits; a full skid holds the whole pipeline.
// ----------------------------------------------------------------------------
module morphological_corner_detector import mcd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] pixel
  input  logic [1:0]  s_tuser,    // [0] frame_start, [1] filler
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [7:0] difference, [18:8] column, [30:19] row
  output logic        m_tuser,    // [0] corner
  output logic        m_tlast,    // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  typedef struct packed {
    logic signed [RW-1:0] row;
    logic [CW-1:0]        col;
  } pos_t;

  // Config registers
  logic [11:0]   line_width;
  logic [HW-1:0] frame_height;
  pix_t          corner_threshold;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic signed [RW-1:0] h_row;

  // Position tracking
  logic hold, fresh;
  pos_t head, ctr1, ctr2, init1, init2;
  pos_t sel_head, sel1, sel2;
  logic acc, sat, adv;

  // Pipeline
  logic s0_valid, s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  pix_t s0_pix;
  logic [CW-1:0] s0_col;
  pos_t s0_c1, s0_c2, s1_c1, s1_c2, s2_c1, s2_c2, s3_c1, s3_c2, s4_c2, s5_c2, s6_c2;
  win_t src_win, crs_win, xb_win;
  pix_t [KS-1:0] s2_crs_rows, s2_x_rows, s5_a_rows, s5_b_rows;
  pix_t s3_da, s3_db, s6_ea, s6_eb;
  logic [KS-1:0][KS-1:0] k_crs, k_x, k_dia, k_sq;

  // Output
  logic push, skid_valid;
  res_t res, out_q, skid_q;
  pix_t diff;

  function automatic pos_t pos_inc(pos_t p, logic [WW-1:0] w);
    pos_t n;
    n = p;
    if ({1'b0, p.col} == w - WW'(1)) begin
      n.col = '0;
      n.row = p.row + RW'(1);
    end else begin
      n.col = p.col + CW'(1);
    end
    return n;
  endfunction

  // Step back by two lines and two pixels in raster order.
  function automatic pos_t pos_back(pos_t p, logic [WW-1:0] w);
    pos_t n;
    if (w == WW'(1)) begin
      n.row = p.row - RW'(4);
      n.col = '0;
    end else if (p.col >= CW'(2)) begin
      n.row = p.row - RW'(2);
      n.col = p.col - CW'(2);
    end else begin
      n.row = p.row - RW'(3);
      n.col = CW'({1'b0, p.col} + w - WW'(2));
    end
    return n;
  endfunction

  function automatic logic [KS-1:0][KS-1:0] keep_mask(pos_t c, shape_t s,
                                                      logic [WW-1:0] w,
                                                      logic signed [RW-1:0] h);
    logic [KS-1:0][KS-1:0] m;
    logic signed [RW-1:0]  rr;
    logic signed [CW+1:0]  cc;
    for (int k = 0; k < KS; k++) begin
      for (int j = 0; j < KS; j++) begin
        rr = c.row + RW'(RAD - k);
        cc = $signed({2'b00, c.col}) + (CW+2)'(RAD - j);
        m[k][j] = in_shape(s, k, j) && (rr >= 0) && (rr < h) && (cc >= 0) &&
                  (cc < $signed({1'b0, w}));
      end
    end
    return m;
  endfunction

  function automatic pix_t [KS-1:0] row_reduce(win_t win, logic [KS-1:0][KS-1:0] keep,
                                               logic take_max);
    pix_t [KS-1:0] rows;
    pix_t [KS-1:0] vals;
    for (int k = 0; k < KS; k++) begin
      for (int j = 0; j < KS; j++) begin
        vals[j] = win[j][k];
      end
      rows[k] = reduce5(vals, keep[k], take_max);
    end
    return rows;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration: zero sizes act as one, oversized sizes saturate.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    if (line_width == 12'd0) begin
      w_eff = WW'(1);
    end else if (int'(line_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(line_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign h_row = $signed({1'b0, h_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width       <= 12'd640;
      frame_height     <= HW'(480);
      corner_threshold <= 8'd40;
      hold             <= 1'b1;
    end else begin
      hold <= cfg_valid;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LINE_WIDTH:   line_width       <= cfg_data[11:0];
          REG_FRAME_HEIGHT: frame_height     <= cfg_data;
          REG_THRESHOLD:    corner_threshold <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Lead-in positions of the two window centers for raster position zero.
  always_ff @(posedge clk) begin
    init1 <= pos_back('0, w_eff);
    init2 <= pos_back(pos_back('0, w_eff), w_eff);
  end

  // --------------------------------------------------------------------------
  // Input side: advance head and both window centers in lockstep.
  // --------------------------------------------------------------------------
  assign adv      = !skid_valid;
  assign s_tready = adv && !hold;
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    if (s_tuser[0] || fresh) begin
      sel_head = '0;
      sel1     = init1;
      sel2     = init2;
    end else begin
      sel_head = head;
      sel1     = ctr1;
      sel2     = ctr2;
    end
  end

  // Once the last pixel has reached the output, drop items until frame start.
  assign sat = !(sel2.row < h_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b1;
      head  <= '0;
      ctr1  <= '0;
      ctr2  <= '0;
    end else if (acc) begin
      fresh <= 1'b0;
      if (sat) begin
        head <= sel_head;
        ctr1 <= sel1;
        ctr2 <= sel2;
      end else begin
        head <= pos_inc(sel_head, w_eff);
        ctr1 <= pos_inc(sel1, w_eff);
        ctr2 <= pos_inc(sel2, w_eff);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline valids
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= acc && !sat;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  // Pipeline payload; a filler inside the frame counts as black.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_pix      <= s_tuser[1] ? 8'd0 : s_tdata;
      s0_col      <= sel_head.col;
      s0_c1       <= sel1;
      s0_c2       <= sel2;
      s1_c1       <= s0_c1;
      s1_c2       <= s0_c2;
      s2_crs_rows <= row_reduce(src_win, k_crs, 1'b1);
      s2_x_rows   <= row_reduce(src_win, k_x, 1'b1);
      s2_c1       <= s1_c1;
      s2_c2       <= s1_c2;
      s3_da       <= reduce5(s2_crs_rows, '1, 1'b1);
      s3_db       <= reduce5(s2_x_rows, '1, 1'b1);
      s3_c1       <= s2_c1;
      s3_c2       <= s2_c2;
      s4_c2       <= s3_c2;
      s5_a_rows   <= row_reduce(crs_win, k_dia, 1'b0);
      s5_b_rows   <= row_reduce(xb_win, k_sq, 1'b0);
      s5_c2       <= s4_c2;
      s6_ea       <= reduce5(s5_a_rows, '1, 1'b0);
      s6_eb       <= reduce5(s5_b_rows, '1, 1'b0);
      s6_c2       <= s5_c2;
    end
  end

  // Only in-frame neighbors of the shape take part.
  assign k_crs = keep_mask(s1_c1, SHAPE_CROSS, w_eff, h_row);
  assign k_x   = keep_mask(s1_c1, SHAPE_X, w_eff, h_row);
  assign k_dia = keep_mask(s4_c2, SHAPE_DIAMOND, w_eff, h_row);
  assign k_sq  = keep_mask(s4_c2, SHAPE_SQUARE, w_eff, h_row);

  // Source window: read line delays at accept, shift the column in next.
  mcd_window #(.MAX_WIDTH(MAX_WIDTH)) u_src_win (
    .clk    (clk),
    .rd_en  (acc && !sat),
    .rd_col (sel_head.col),
    .sh_en  (adv && s0_valid),
    .sh_col (s0_col),
    .sh_pix (s0_pix),
    .win    (src_win)
  );

  // Branch windows take the dilated values in raster order of the center.
  mcd_window #(.MAX_WIDTH(MAX_WIDTH)) u_crs_win (
    .clk    (clk),
    .rd_en  (adv && s2_valid),
    .rd_col (s2_c1.col),
    .sh_en  (adv && s3_valid),
    .sh_col (s3_c1.col),
    .sh_pix (s3_da),
    .win    (crs_win)
  );

  mcd_window #(.MAX_WIDTH(MAX_WIDTH)) u_xb_win (
    .clk    (clk),
    .rd_en  (adv && s2_valid),
    .rd_col (s2_c1.col),
    .sh_en  (adv && s3_valid),
    .sh_col (s3_c1.col),
    .sh_pix (s3_db),
    .win    (xb_win)
  );

  // --------------------------------------------------------------------------
  // Result and output register with skid
  // --------------------------------------------------------------------------
  assign diff = (s6_ea > s6_eb) ? s6_ea - s6_eb : s6_eb - s6_ea;
  assign push = adv && s6_valid && (s6_c2.row >= 0) && (s6_c2.row < h_row);

  always_comb begin
    res.corner    = diff > corner_threshold;
    res.diff      = diff;
    res.column    = 11'(s6_c2.col);
    res.row       = 12'(s6_c2.row);
    res.frame_end = (s6_c2.row == h_row - RW'(1)) && ({1'b0, s6_c2.col} == w_eff - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_tdata = {1'b0, out_q.row, out_q.column, out_q.diff};
  assign m_tuser = out_q.corner;
  assign m_tlast = out_q.frame_end;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid holds data with output empty");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !skid_valid) else $error("input ready while skid is full");

  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> !s_tready) else $error("input taken before positions settle");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[30:19] == 12'(h_eff - HW'(1))))
    else $error("frame end flagged off the last row");

endmodule

[rtl/mcd_line_mem.sv]
// ----------------------------------------------------------------------------
// mcd_line_mem
// One line of delay: single write port, registered read with write bypass.
// ----------------------------------------------------------------------------
module mcd_line_mem import mcd_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output pix_t          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pix_t          wr_data
);

  pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Forward a same-cycle write so a one-pixel line still sees fresh data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

endmodule

[rtl/mcd_cell.sv]
// ----------------------------------------------------------------------------
// mcd_cell
// One window column: holds five vertically stacked pixels, shifts right.
// ----------------------------------------------------------------------------
module mcd_cell import mcd_pkg::*; (
  input  logic clk,
  input  logic en,
  input  col_t din,
  output col_t dout
);

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= din;
    end
  end

endmodule

[rtl/mcd_window.sv]
// ----------------------------------------------------------------------------
// mcd_window
// 5x5 raster window: four line delays feed a chain of five column cells.
// ----------------------------------------------------------------------------
module mcd_window import mcd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  input  logic                         sh_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] sh_col,
  input  pix_t                         sh_pix,
  output win_t                         win
);

  localparam int CW = $clog2(MAX_WIDTH);

  col_t tap;
  pix_t rd [KS-1];

  assign tap[0] = sh_pix;

  for (genvar m = 0; m < KS - 1; m++) begin : g_line
    mcd_line_mem #(.DEPTH(MAX_WIDTH), .AW(CW)) u_mem (
      .clk     (clk),
      .rd_en   (rd_en),
      .rd_addr (rd_col),
      .rd_data (rd[m]),
      .wr_en   (sh_en),
      .wr_addr (sh_col),
      .wr_data (tap[m])
    );
    assign tap[m+1] = rd[m];
  end

  for (genvar j = 0; j < KS; j++) begin : g_cell
    mcd_cell u_cell (
      .clk  (clk),
      .en   (sh_en),
      .din  ((j == 0) ? tap : win[(j == 0) ? 0 : j - 1]),
      .dout (win[j])
    );
  end

endmodule

[dv/mcd_checker.sv]
// ----------------------------------------------------------------------------
// mcd_checker
// Watches the pixel, result and register channels of the corner detector,
// predicts every result from its own copy of the line stores and compares
// the results in order.
// ----------------------------------------------------------------------------
module mcd_checker import mcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES = 8;
  localparam int WMAX  = 2048;

  pix_t src_store [LINES][WMAX];
  pix_t cross_store [LINES][WMAX];
  pix_t x_store [LINES][WMAX];

  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [7:0]  thr_reg;
  longint      in_col, in_row;
  res_t        expected_q[$];

  function automatic pix_t read_store(int sel, int r, int c);
    case (sel)
      0: return src_store[r % LINES][c];
      1: return cross_store[r % LINES][c];
      default: return x_store[r % LINES][c];
    endcase
  endfunction

  // Max or min over the shape, skipping positions outside the frame.
  function automatic pix_t shape_reduce(int sel, int r, int c, int w, int h,
                                        shape_t s, bit take_max);
    pix_t acc, v;
    int ay, ax;
    bit hit;
    acc = take_max ? 8'd0 : 8'd255;
    for (int dy = -RAD; dy <= RAD; dy++) begin
      for (int dx = -RAD; dx <= RAD; dx++) begin
        ay = dy < 0 ? -dy : dy;
        ax = dx < 0 ? -dx : dx;
        case (s)
          SHAPE_CROSS:   hit = (ay == 0) || (ax == 0);
          SHAPE_X:       hit = (ay == ax);
          SHAPE_DIAMOND: hit = (ay + ax) <= RAD;
          default:       hit = 1'b1;
        endcase
        if (hit && r + dy >= 0 && r + dy < h && c + dx >= 0 && c + dx < w) begin
          v = read_store(sel, r + dy, c + dx);
          if (take_max ? (v > acc) : (v < acc)) acc = v;
        end
      end
    end
    return acc;
  endfunction

  // Advance the raster position by one item and push the result it causes.
  task automatic predict_pixel(pix_t pix, bit start, bit fill);
    longint w, h, frame, lag, lim, p, q;
    int r, c;
    pix_t a, b, d;
    res_t exp_res;
    w = (width_reg == 0) ? 1 : (width_reg > WMAX) ? WMAX : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    frame = w * h;
    lag = 2 * w + 2;
    lim = frame + 2 * lag;
    if (start) begin
      in_col = 0;
      in_row = 0;
    end
    p = in_row * w + in_col;
    if (p > lim) p = lim;
    if (p < frame) src_store[(p / w) % LINES][p % w] = fill ? 8'd0 : pix;
    if (p >= lag && p - lag < frame) begin
      q = p - lag;
      r = q / w;
      c = q % w;
      cross_store[r % LINES][c] = shape_reduce(0, r, c, w, h, SHAPE_CROSS, 1'b1);
      x_store[r % LINES][c] = shape_reduce(0, r, c, w, h, SHAPE_X, 1'b1);
    end
    if (p >= 2 * lag && p - 2 * lag < frame) begin
      q = p - 2 * lag;
      r = q / w;
      c = q % w;
      a = shape_reduce(1, r, c, w, h, SHAPE_DIAMOND, 1'b0);
      b = shape_reduce(2, r, c, w, h, SHAPE_SQUARE, 1'b0);
      d = (a > b) ? a - b : b - a;
      exp_res.corner    = d > thr_reg;
      exp_res.diff      = d;
      exp_res.column    = c[10:0];
      exp_res.row       = r[11:0];
      exp_res.frame_end = (q == frame - 1);
      expected_q.push_back(exp_res);
    end
    if (p < lim) p++;
    in_row = p / w;
    in_col = p % w;
  endtask

  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      width_reg  <= 12'd640;
      height_reg <= 13'd480;
      thr_reg    <= 8'd40;
      in_col     = 0;
      in_row     = 0;
      expected_q.delete();
      errors     <= 0;
      results    <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tuser, m_tdata[7:0], m_tdata[18:8], m_tdata[30:19], m_tlast};
        results <= results + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("[%0t] unexpected result %p", $realtime, got);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("[%0t] mismatch: expected %p, got %p",
                                      $realtime, want, got);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_LINE_WIDTH:   width_reg  <= cfg_data[11:0];
          REG_FRAME_HEIGHT: height_reg <= cfg_data;
          REG_THRESHOLD:    thr_reg    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_pixel(s_tdata, s_tuser[0], s_tuser[1]);
    end
    pending <= expected_q.size();
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the corner detector: frames of random gray
// levels over many sizes, in-frame filler, restarts and drain items, with
// random gaps on both sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import mcd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 20;     // covers the pipeline and the skid
  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;      // [0] frame_start, [1] filler
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [7:0] difference, [18:8] column, [30:19] row
  logic        m_tuser;           // [0] corner
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  int  errors, pending, results;
  int  pixels_sent = 0;
  int  frames_run = 0;
  int  idle_cycles = 0;
  bit  tx_steady = 0;             // no gaps on the pixel side when set
  bit  rx_steady = 0;             // no stalls on the result side when set
  int  width_eff = 640, height_eff = 480;

  always #4 clk = ~clk;

  morphological_corner_detector i_dut (.*);

  mcd_checker i_checker (.*);

  // Watchdog: end the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: hold off each result for a random stall, then take it.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Drive one pixel request; valid stays high across back-to-back requests.
  task automatic send_pixel(logic [7:0] pix, bit start, bit fill);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= {fill, start};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    pixels_sent++;
  endtask

  // Let the pipeline drain completely before touching a register.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_LINE_WIDTH)
      width_eff = (val[11:0] == 0) ? 1 : (val[11:0] > 2048) ? 2048 : val[11:0];
    if (idx == REG_FRAME_HEIGHT)
      height_eff = (val == 0) ? 1 : (val > MAX_HEIGHT) ? MAX_HEIGHT : val;
  endtask

  task automatic set_sizes(logic [12:0] w, logic [12:0] h, logic [7:0] thr);
    wait_idle();
    write_reg(REG_LINE_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_THRESHOLD, {5'd0, thr});
  endtask

  // One frame: random pixels, some filler inside, an optional restart,
  // then drain items (random filler bit, ignored past the frame) and extras.
  task automatic run_frame(int fill_pct, bit restart, int extra);
    int npix, lag, cut;
    npix = width_eff * height_eff;
    lag  = 2 * width_eff + 2;
    if (restart) begin
      cut = $urandom_range(1, npix);
      for (int i = 0; i < cut; i++)
        send_pixel($urandom, i == 0, $urandom_range(0, 99) < fill_pct);
    end
    for (int i = 0; i < npix; i++)
      send_pixel($urandom, i == 0, $urandom_range(0, 99) < fill_pct);
    for (int i = 0; i < 2 * lag + extra; i++)
      send_pixel($urandom, 1'b0, $urandom_range(0, 1));
    frames_run++;
  endtask

  initial begin
    logic [7:0] corner_px [9];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: 3x3 frame of extreme levels with one filler, threshold 0.
    corner_px = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128};
    set_sizes(13'd3, 13'd3, 8'd0);
    for (int i = 0; i < 9; i++) send_pixel(corner_px[i], i == 0, i == 4);
    for (int i = 0; i < 16; i++) send_pixel(8'hFF, 1'b0, i[0]);

    // Random small frames, bursty and steady stretches mixed.
    while (pixels_sent < 850) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      set_sizes($urandom_range(1, 12), $urandom_range(1, 6),
                ($urandom_range(0, 3) == 0) ? 8'd0 : $urandom_range(0, 120));
      run_frame($urandom_range(0, 15), $urandom_range(0, 4) == 0,
                $urandom_range(0, 1) ? $urandom_range(1, 6) : 0);
    end

    // Size extremes: zero sizes act as 1, oversized values saturate.
    tx_steady = 0;
    rx_steady = 0;
    set_sizes(13'd0, 13'd0, 8'd255);
    run_frame(0, 0, 3);
    set_sizes(13'd4096, 13'd1, 8'd0);
    run_frame(10, 0, 0);
    set_sizes(13'd2048, 13'd1, 8'd10);
    run_frame(5, 0, 0);
    tx_steady = 1;
    set_sizes(13'd4095, 13'd2, 8'd255);
    run_frame(5, 0, 0);
    set_sizes(13'd1, 13'd8191, 8'd30);
    run_frame(5, 0, 0);
    tx_steady = 0;
    set_sizes(13'd1, 13'd4096, 8'd0);
    run_frame(0, 0, 2);

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d frames, %0d pixel requests, %0d results checked.",
             frames_run, pixels_sent, results);
    $display("Sizes from 1x1 up to saturated widths and heights, thresholds 0 to 255.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mcd_pkg.sv
rtl/mcd_line_mem.sv
rtl/mcd_cell.sv
rtl/mcd_window.sv
rtl/morphological_corner_detector.sv
dv/mcd_checker.sv
dv/tb_top.sv
